// File: rtl/uqpd_pkg.sv
// Package with shared types, codes and helpers of the URL query parameter decoder.
package uqpd_pkg;

    // Result kinds as seen on the result channel.
    typedef enum logic [2:0] {
        KIND_KEY      = 3'd0,
        KIND_VALUE    = 3'd1,
        KIND_KEPT     = 3'd2,
        KIND_DROPPED  = 3'd3,
        KIND_DONE_OK  = 3'd4,
        KIND_DONE_ERR = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_ESCAPES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CR      = 1'd1;

    // Depth of the result queue; a power of two, at least two, so the pointers wrap cleanly.
    localparam int RES_DEPTH = 4;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0d;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic       in_key_mode;
        logic       key_nonempty;
        esc_phase_t escape_phase;
        logic [3:0] high_nibble;
        logic       error_seen;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        in_key_mode:  1'b1,
        key_nonempty: 1'b0,
        escape_phase: ESC_NONE,
        high_nibble:  4'd0,
        error_seen:   1'b0
    };

    typedef struct packed {
        logic decode_escapes;
        logic ignore_cr;
    } dec_cfg_t;

    // Uppercase hex digit: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] res;
        begin
            res = 5'd0;
            if (ch >= 8'h30 && ch <= 8'h39)
            begin
                res = {1'b1, ch[3:0]};
            end
            else if (ch >= 8'h41 && ch <= 8'h46)
            begin
                res = {1'b1, ch[3:0] + 4'd9};
            end
            return res;
        end
    endfunction

endpackage

// File: rtl/uqpd_if.sv
// Handshake interfaces for the text, result and configuration channels.
interface uqpd_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface uqpd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       run_last;

    modport source (output valid, output kind, output data_byte, output run_last, input ready);
    modport sink   (input valid, input kind, input data_byte, input run_last, output ready);
endinterface

interface uqpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [0:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/uqpd_step.sv
// Per-byte decode: next parser state and up to two results for one text byte.
module uqpd_step (
    input  uqpd_pkg::dec_state_t state,
    input  uqpd_pkg::dec_cfg_t   cfg,
    input  logic [7:0]           text_byte,
    output uqpd_pkg::dec_state_t state_next,
    output logic [1:0]           res_count,
    output uqpd_pkg::result_t    res0,
    output uqpd_pkg::result_t    res1
);
    import uqpd_pkg::*;

    logic [4:0] digit;
    logic [7:0] esc_value;

    assign digit     = hex_digit(text_byte);
    assign esc_value = {state.high_nibble, digit[3:0]};

    always_comb
    begin
        state_next = state;
        res_count  = 2'd0;
        res0       = '{kind: KIND_KEY, data_byte: 8'd0, run_last: 1'b0};
        res1       = '{kind: KIND_KEY, data_byte: 8'd0, run_last: 1'b0};

        priority if (text_byte == CH_NUL)
        begin
            if (state.error_seen)
            begin
                res0.kind = KIND_DONE_ERR;
                res_count = 2'd1;
            end
            else
            begin
                res0.kind = state.key_nonempty ? KIND_KEPT : KIND_DROPPED;
                res1.kind = KIND_DONE_OK;
                res_count = 2'd2;
            end
            state_next = STATE_RESET;
        end
        else if (state.error_seen)
        begin
            // swallow everything up to the terminator
        end
        else if (state.escape_phase == ESC_HIGH)
        begin
            if (!digit[4])
            begin
                state_next.error_seen   = 1'b1;
                state_next.escape_phase = ESC_NONE;
            end
            else
            begin
                state_next.high_nibble  = digit[3:0];
                state_next.escape_phase = ESC_LOW;
            end
        end
        else if (state.escape_phase == ESC_LOW)
        begin
            state_next.escape_phase = ESC_NONE;
            state_next.high_nibble  = 4'd0;
            if (!digit[4])
            begin
                state_next.error_seen = 1'b1;
            end
            else if (!(esc_value == CH_CR && cfg.ignore_cr))
            begin
                res0.kind      = state.in_key_mode ? KIND_KEY : KIND_VALUE;
                res0.data_byte = esc_value;
                res_count      = 2'd1;
                if (state.in_key_mode)
                begin
                    state_next.key_nonempty = 1'b1;
                end
            end
        end
        else if (text_byte == CH_EQUALS)
        begin
            state_next.in_key_mode = 1'b0;
        end
        else if (text_byte == CH_AMP)
        begin
            res0.kind               = state.key_nonempty ? KIND_KEPT : KIND_DROPPED;
            res_count               = 2'd1;
            state_next.key_nonempty = 1'b0;
            state_next.in_key_mode  = 1'b1;
        end
        else if (text_byte == CH_PERCENT && cfg.decode_escapes)
        begin
            state_next.escape_phase = ESC_HIGH;
            state_next.high_nibble  = 4'd0;
        end
        else
        begin
            res0.kind      = state.in_key_mode ? KIND_KEY : KIND_VALUE;
            res0.data_byte = (text_byte == CH_PLUS) ? CH_SPACE : text_byte;
            res_count      = 2'd1;
            if (state.in_key_mode)
            begin
                state_next.key_nonempty = 1'b1;
            end
        end

        // Flag the last result of this byte.
        if (res_count == 2'd2)
        begin
            res1.run_last = 1'b1;
        end
        else if (res_count == 2'd1)
        begin
            res0.run_last = 1'b1;
        end
    end

endmodule

// File: rtl/url_query_param_decoder.sv
// Top level of the URL query parameter decoder: input register, decode, result queue.
// An accepted byte waits in the input register until it is decoded into the result queue.
// Throughput: one text byte per cycle when not held off; a terminator's two results take an
// extra result transaction. Input is held off only when the queue lacks room for two results.
// Reset (rst_n low, asynchronous): parser back to key mode with no escape or error, queue empty,
//   decode_escapes reset to 1 and ignore_cr to 0.
module url_query_param_decoder (
    input  logic               clk,
    input  logic               rst_n,
    uqpd_text_if.sink          text,
    uqpd_result_if.source      result,
    uqpd_cfg_if.sink           cfg
);
    import uqpd_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    // Configuration registers
    logic decode_escapes_reg;
    logic ignore_cr_reg;
    dec_cfg_t dec_cfg;

    // Input register stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // Parser state
    dec_state_t state_reg;
    dec_state_t state_next;

    // Decode outputs
    logic [1:0] res_count;
    result_t    res0;
    result_t    res1;

    // Result queue
    result_t            res_mem [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic text_take;
    logic advance;
    logic pop;

    assign dec_cfg = '{decode_escapes: decode_escapes_reg, ignore_cr: ignore_cr_reg};

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_escapes_reg <= 1'b1;
            ignore_cr_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DECODE_ESCAPES: decode_escapes_reg <= cfg.data[0];
                CFG_IGNORE_CR:      ignore_cr_reg      <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    // Advance the input register only when the queue can absorb the worst case of two results.
    assign advance   = in_valid_reg && (count_reg <= CNT_W'(RES_DEPTH - 2));
    assign text.ready = !in_valid_reg || advance;
    assign text_take = text.valid && text.ready;
    assign pop       = result.valid && result.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            in_byte_reg <= text.text_byte;
        end
    end

    uqpd_step u_step (
        .state      (state_reg),
        .cfg        (dec_cfg),
        .text_byte  (in_byte_reg),
        .state_next (state_next),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Push up to two results per byte; pop one per result transaction.
    always_ff @(posedge clk)
    begin
        if (advance && res_count != 2'd0)
        begin
            res_mem[wr_ptr_reg] <= res0;
        end
        if (advance && res_count == 2'd2)
        begin
            res_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (advance)
        begin
            count_next = count_next + CNT_W'(res_count);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Head of the queue drives the result channel.
    assign result.valid     = (count_reg != '0);
    assign result.kind      = res_mem[rd_ptr_reg].kind;
    assign result.data_byte = res_mem[rd_ptr_reg].data_byte;
    assign result.run_last  = res_mem[rd_ptr_reg].run_last;

endmodule

// File: rtl/uqpd_checker.sv
// Port-level checks on the result channel of the decoder, bound to the top level.
module uqpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_kind,
    input logic [7:0] res_data_byte,
    input logic       res_run_last
);
    import uqpd_pkg::*;

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_data_byte) && $stable(res_run_last))
        else $error("result changed while stalled");

    // Only key and value results carry a character.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_KEY && res_kind != KIND_VALUE |-> res_data_byte == 8'd0)
        else $error("non-data result with nonzero data byte");

    // Data and done results always close out their byte.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_KEY || res_kind == KIND_VALUE
            || res_kind == KIND_DONE_OK || res_kind == KIND_DONE_ERR) |-> res_run_last)
        else $error("data or done result without run_last");

    // The only non-final result is the kept or dropped result flushed by the terminator.
    a_flush_first: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_run_last |-> res_kind == KIND_KEPT || res_kind == KIND_DROPPED)
        else $error("unexpected result ahead of run_last");

    // The flushed kept or dropped result is followed by done ok.
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_run_last |=> res_valid && res_kind == KIND_DONE_OK)
        else $error("flushed pair not followed by done ok");

endmodule

bind url_query_param_decoder uqpd_checker u_uqpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_kind      (result.kind),
    .res_data_byte (result.data_byte),
    .res_run_last  (result.run_last)
);

// File: bench/tb_top.sv
// Testbench of the URL query parameter decoder: directed table, then random query strings.
module tb_top;
    import uqpd_pkg::*;

    // Directed table rows: a text byte to send, or a register write.
    typedef enum logic {
        ROW_TEXT = 1'b0,
        ROW_CFG  = 1'b1
    } row_op_t;

    // nres >= 0 types the results in directly: k0/d0 for the first,
    // k1 for the second (always a status kind with zero data).
    // nres < 0 leaves the row to the predictor. For ROW_CFG rows,
    // ch[0] carries the register value.
    typedef struct packed {
        row_op_t                op;
        logic [7:0]             ch;
        logic [CFG_IDX_W-1:0]   reg_idx;
        int                     nres;
        kind_t                  k0;
        logic [7:0]             d0;
        kind_t                  k1;
    } dir_row_t;

    localparam int DIR_ROWS = 29;
    localparam logic [CFG_IDX_W-1:0] NO_REG = CFG_DECODE_ESCAPES;

    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // Empty string: the empty last pair is dropped, then done.
        '{ROW_TEXT, CH_NUL,     NO_REG, 2, KIND_DROPPED, 8'h00,    KIND_DONE_OK},
        '{ROW_TEXT, "a",        NO_REG, 1, KIND_KEY,     "a",      KIND_KEY},
        '{ROW_TEXT, CH_EQUALS,  NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, 8'hff,      NO_REG, 1, KIND_VALUE,   8'hff,    KIND_KEY},
        '{ROW_TEXT, CH_PLUS,    NO_REG, 1, KIND_VALUE,   CH_SPACE, KIND_KEY},
        '{ROW_TEXT, CH_AMP,     NO_REG, 1, KIND_KEPT,    8'h00,    KIND_KEY},
        // Second '&' right away: the key is empty, so the pair is dropped.
        '{ROW_TEXT, CH_AMP,     NO_REG, 1, KIND_DROPPED, 8'h00,    KIND_KEY},
        // Escaped carriage return passes while ignore_cr is clear.
        '{ROW_TEXT, CH_PERCENT, NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "0",        NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "D",        NO_REG, 1, KIND_KEY,     CH_CR,    KIND_KEY},
        // '=' taken as an escape digit is a bad digit: error, then swallow.
        '{ROW_TEXT, CH_PERCENT, NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, CH_EQUALS,  NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "x",        NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, CH_NUL,     NO_REG, 1, KIND_DONE_ERR, 8'h00,   KIND_KEY},
        '{ROW_CFG,  8'h01,      CFG_IGNORE_CR, -1, KIND_KEY, 8'h00, KIND_KEY},
        // Suppressed carriage return leaves the key empty.
        '{ROW_TEXT, CH_PERCENT, NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "0",        NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "D",        NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        // Escape cut short by the terminator is dropped.
        '{ROW_TEXT, CH_PERCENT, NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, "F",        NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_TEXT, CH_NUL,     NO_REG, 2, KIND_DROPPED, 8'h00,    KIND_DONE_OK},
        // Open an escape, then turn decoding off: the escape still completes,
        // and its decoded zero byte makes the key non-empty.
        '{ROW_TEXT, CH_PERCENT, NO_REG, 0, KIND_KEY,     8'h00,    KIND_KEY},
        '{ROW_CFG,  8'h00,      CFG_DECODE_ESCAPES, -1, KIND_KEY, 8'h00, KIND_KEY},
        '{ROW_TEXT, "0",        NO_REG, -1, KIND_KEY,    8'h00,    KIND_KEY},
        '{ROW_TEXT, "0",        NO_REG, -1, KIND_KEY,    8'h00,    KIND_KEY},
        '{ROW_TEXT, CH_PERCENT, NO_REG, 1, KIND_KEY,     CH_PERCENT, KIND_KEY},
        '{ROW_TEXT, CH_NUL,     NO_REG, 2, KIND_KEPT,    8'h00,    KIND_DONE_OK},
        '{ROW_CFG,  8'h01,      CFG_DECODE_ESCAPES, -1, KIND_KEY, 8'h00, KIND_KEY},
        '{ROW_CFG,  8'h00,      CFG_IGNORE_CR, -1, KIND_KEY, 8'h00, KIND_KEY}
    };

    // Random phases: bit 1 is decode_escapes, bit 0 is ignore_cr.
    localparam int PHASES = 4;
    localparam int PHASE_ITEMS = 175;
    localparam logic [1:0] PHASE_CFG [0:PHASES-1] = '{2'b11, 2'b00, 2'b10, 2'b01};

    logic clk;
    logic rst_n;

    uqpd_text_if   text_ch ();
    uqpd_result_if res_ch ();
    uqpd_cfg_if    cfg_ch ();

    url_query_param_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the decoder: registers and parser state.
    logic       esc_on;
    logic       cr_drop;
    logic       key_mode;
    logic       key_seen;
    esc_phase_t esc_state;
    logic [3:0] hi_nib;
    logic       err_flag;

    result_t expected_results [$];
    int      errors;
    int      sent;

    // Typed expectations of the byte currently offered on the text channel.
    int         cur_nres;
    kind_t      cur_k0;
    logic [7:0] cur_d0;
    kind_t      cur_k1;

    // Idle control: steady stretches switch gaps off on either side.
    logic steady;
    logic sink_steady;
    int   stall_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the shadow state by one text byte and return the results it causes.
    function automatic int decode_char(input logic [7:0] ch, output result_t r0,
                                       output result_t r1);
        logic       hex_ok;
        logic [7:0] digit8;
        logic [7:0] val;
        logic       emit;
        int         n;
        begin
            n = 0;
            r0 = '0;
            r1 = '0;
            emit = 1'b0;
            val = ch;
            hex_ok = (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F");
            digit8 = (ch <= "9") ? ch - "0" : ch - "A" + 8'd10;
            if (ch == CH_NUL)
            begin
                if (err_flag)
                begin
                    r0.kind = KIND_DONE_ERR;
                    n = 1;
                end
                else
                begin
                    r0.kind = key_seen ? KIND_KEPT : KIND_DROPPED;
                    r1.kind = KIND_DONE_OK;
                    n = 2;
                end
                key_mode = 1'b1;
                key_seen = 1'b0;
                esc_state = ESC_NONE;
                hi_nib = 4'd0;
                err_flag = 1'b0;
            end
            else if (err_flag)
            begin
                n = 0;
            end
            else if (esc_state == ESC_HIGH)
            begin
                if (!hex_ok)
                begin
                    err_flag = 1'b1;
                    esc_state = ESC_NONE;
                end
                else
                begin
                    hi_nib = digit8[3:0];
                    esc_state = ESC_LOW;
                end
            end
            else if (esc_state == ESC_LOW)
            begin
                esc_state = ESC_NONE;
                val = {hi_nib, digit8[3:0]};
                if (!hex_ok)
                    err_flag = 1'b1;
                else
                    emit = !(val == CH_CR && cr_drop);
                hi_nib = 4'd0;
            end
            else if (ch == CH_EQUALS)
            begin
                key_mode = 1'b0;
            end
            else if (ch == CH_AMP)
            begin
                r0.kind = key_seen ? KIND_KEPT : KIND_DROPPED;
                n = 1;
                key_seen = 1'b0;
                key_mode = 1'b1;
            end
            else if (ch == CH_PERCENT && esc_on)
            begin
                esc_state = ESC_HIGH;
                hi_nib = 4'd0;
            end
            else
            begin
                emit = 1'b1;
                val = (ch == CH_PLUS) ? CH_SPACE : ch;
            end

            if (emit)
            begin
                r0.kind = key_mode ? KIND_KEY : KIND_VALUE;
                r0.data_byte = val;
                if (key_mode)
                    key_seen = 1'b1;
                n = 1;
            end
            if (n == 1)
                r0.run_last = 1'b1;
            else if (n == 2)
                r1.run_last = 1'b1;
            return n;
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(4, 20);
        end
    endfunction

    function automatic logic [7:0] alnum_char();
        int k;
        begin
            k = $urandom_range(0, 61);
            if (k < 10)
                return 8'(k) + "0";
            else if (k < 36)
                return 8'(k - 10) + "A";
            return 8'(k - 36) + "a";
        end
    endfunction

    function automatic logic [7:0] hex_char();
        int k;
        begin
            k = $urandom_range(0, 15);
            if (k < 10)
                return 8'(k) + "0";
            return 8'(k - 10) + "A";
        end
    endfunction

    // Offer one byte and hold it until the transaction completes.
    task automatic send_text(input logic [7:0] ch, input int nres, input kind_t k0,
                             input logic [7:0] d0, input kind_t k1);
        int idle;
        begin
            idle = steady ? 0 : pick_gap();
            @(negedge clk);
            if (idle > 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            cur_nres = nres;
            cur_k0 = k0;
            cur_d0 = d0;
            cur_k1 = k1;
            text_ch.valid <= 1'b1;
            text_ch.text_byte <= ch;
            do @(posedge clk); while (!text_ch.ready);
            sent++;
        end
    endtask

    task automatic push_byte(input logic [7:0] ch);
        send_text(ch, -1, KIND_KEY, 8'h00, KIND_KEY);
    endtask

    // Drop text valid, drain every expected result, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One character of a key or value: plain, '+', escapes good and bad, noise.
    task automatic send_field_char();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                push_byte(alnum_char());
            else if (r < 55)
                push_byte(CH_PLUS);
            else if (r < 59)
            begin
                push_byte(CH_PERCENT);
                push_byte("0");
                push_byte("D");
            end
            else if (r < 75)
            begin
                push_byte(CH_PERCENT);
                push_byte(hex_char());
                push_byte(hex_char());
            end
            else if (r < 80)
            begin
                // Escape whose first digit sits just outside the hex ranges, is lowercase, or is anything.
                push_byte(CH_PERCENT);
                case ($urandom_range(0, 7))
                    0: push_byte("/");
                    1: push_byte(":");
                    2: push_byte("@");
                    3: push_byte("G");
                    4: push_byte("a");
                    5: push_byte("f");
                    default: push_byte(8'($urandom_range(1, 255)));
                endcase
                push_byte(8'($urandom_range(1, 255)));
            end
            else if (r < 84)
            begin
                push_byte(CH_PERCENT);
                push_byte(8'($urandom_range("a", "f")));
                push_byte(hex_char());
            end
            else if (r < 92)
                push_byte(8'($urandom_range(1, 255)));
            else
                push_byte(8'($urandom_range(128, 255)));
        end
    endtask

    // One query string, terminator included. Most are well formed with
    // random content; a few are pure noise or end inside an escape.
    task automatic send_query();
        int r;
        int pairs;
        int len;
        begin
            steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                len = $urandom_range(1, 12);
                repeat (len) push_byte(8'($urandom_range(1, 255)));
            end
            else
            begin
                pairs = $urandom_range(0, 4);
                for (int p = 0; p < pairs; p++)
                begin
                    if (p > 0)
                    begin
                        push_byte(CH_AMP);
                        if ($urandom_range(0, 7) == 0)
                            push_byte(CH_AMP);
                    end
                    len = $urandom_range(0, 4);
                    repeat (len) send_field_char();
                    if ($urandom_range(0, 3) != 0)
                    begin
                        push_byte(CH_EQUALS);
                        len = $urandom_range(0, 5);
                        repeat (len) send_field_char();
                    end
                end
                if (r == 1)
                begin
                    push_byte(CH_PERCENT);
                    if ($urandom_range(0, 1) == 1)
                        push_byte(hex_char());
                end
            end
            push_byte(CH_NUL);
        end
    endtask

    // Result channel backpressure: random stalls, with steady stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
        if ($urandom_range(0, 299) == 0)
            sink_steady = !sink_steady;
    end

    // Track register writes, predict on each text transaction, and check
    // each result transaction against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        result_t p0;
        result_t p1;
        result_t want;
        int      n;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_DECODE_ESCAPES: esc_on = cfg_ch.data;
                    CFG_IGNORE_CR:      cr_drop = cfg_ch.data;
                    default: ;
                endcase
            end

            if (text_ch.valid && text_ch.ready)
            begin
                n = decode_char(text_ch.text_byte, p0, p1);
                // Typed rows override the prediction; the shadow state still advances.
                if (cur_nres >= 0)
                begin
                    n = cur_nres;
                    p0 = '{kind: cur_k0, data_byte: cur_d0, run_last: (cur_nres == 1)};
                    p1 = '{kind: cur_k1, data_byte: 8'h00, run_last: 1'b1};
                end
                if (n > 0)
                    expected_results.push_back(p0);
                if (n > 1)
                    expected_results.push_back(p1);
            end

            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d data_byte 0x%02h run_last %0d",
                           res_ch.kind, res_ch.data_byte, res_ch.run_last);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                        errors++;
                    end
                    if (res_ch.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected 0x%02h, got 0x%02h",
                               want.data_byte, res_ch.data_byte);
                        errors++;
                    end
                    if (res_ch.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d",
                               want.run_last, res_ch.run_last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        text_ch.valid = 1'b0;
        text_ch.text_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_DECODE_ESCAPES;
        cfg_ch.data = 1'b0;
        res_ch.ready = 1'b0;
        stall_left = 0;
        sink_steady = 1'b0;
        steady = 1'b0;
        errors = 0;
        sent = 0;
        cur_nres = -1;
        cur_k0 = KIND_KEY;
        cur_d0 = 8'h00;
        cur_k1 = KIND_KEY;

        // Shadow starts in the reset state of the block.
        esc_on = 1'b1;
        cr_drop = 1'b0;
        key_mode = 1'b1;
        key_seen = 1'b0;
        esc_state = ESC_NONE;
        hi_nib = 4'd0;
        err_flag = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; register writes wait for the block to go idle.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].op == ROW_CFG)
            begin
                wait_idle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].ch[0]);
            end
            else
            begin
                send_text(DIRECTED[i].ch, DIRECTED[i].nres, DIRECTED[i].k0,
                          DIRECTED[i].d0, DIRECTED[i].k1);
            end
        end

        // Random query strings under each register setting in turn.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_reg(CFG_DECODE_ESCAPES, PHASE_CFG[ph][1]);
            write_reg(CFG_IGNORE_CR, PHASE_CFG[ph][0]);
            while (sent < DIR_ROWS + (ph + 1) * PHASE_ITEMS)
                send_query();
        end

        wait_idle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
